// File: hdl/dns_ap_pkg.sv
`default_nettype none
package dns_ap_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int PEND_IDX_W    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  localparam logic [15:0] HDR_LEN      = 16'd12;
  localparam logic [15:0] QFOOT_LEN    = 16'd4;
  localparam logic [15:0] AFOOT_LEN    = 16'd10;
  localparam logic [15:0] ADDR_LEN     = 16'd4;
  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [7:0]  POINTER_MASK = 8'hc0;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  localparam logic STATUS_RESOLVED = 1'b0;
  localparam logic STATUS_FULL     = 1'b1;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QLEN   = 4'd1,
    PH_QSKIP  = 4'd2,
    PH_QPTR   = 4'd3,
    PH_QFOOT  = 4'd4,
    PH_ALEN   = 4'd5,
    PH_ASKIP  = 4'd6,
    PH_APTR   = 4'd7,
    PH_AFOOT  = 4'd8,
    PH_RSKIP  = 4'd9,
    PH_ADDR   = 4'd10,
    PH_DONE   = 4'd11
  } phase_t;

endpackage
`default_nettype wire

// File: hdl/dns_ap_in_if.sv
`default_nettype none
interface dns_ap_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  packet_byte;
  logic        end_of_packet;
  logic [15:0] query_id;
  logic [7:0]  request_tag;

  modport source (
    output valid, action, packet_byte, end_of_packet, query_id, request_tag,
    input  ready
  );
  modport sink (
    input  valid, action, packet_byte, end_of_packet, query_id, request_tag,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/dns_ap_out_if.sv
`default_nettype none
interface dns_ap_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] resolved_address;
  logic [7:0]  tag_out;

  modport source (
    output valid, status, resolved_address, tag_out,
    input  ready
  );
  modport sink (
    input  valid, status, resolved_address, tag_out,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/dns_answer_parser.sv
// A result appears in the output register in the cycle after the transfer that causes it.
// Throughput: one item per cycle unless output stalls; the output register refills as it empties.
// Parsing and the pending-table lookup are done in one pass on each accepted byte.
// Reset (synchronous, active low) returns the parser to the header phase and frees every
// pending entry; the stored identifiers and tags are not cleared.
`default_nettype none
module dns_answer_parser
  import dns_ap_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  dns_ap_in_if.sink        in_item,
  dns_ap_out_if.source     out_result
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] questions_left_r, questions_left_nxt;
  logic [15:0] answers_left_r, answers_left_nxt;
  logic [15:0] packet_ident_r, packet_ident_nxt;
  logic [15:0] record_kind_r, record_kind_nxt;
  logic [15:0] data_length_r, data_length_nxt;
  logic [31:0] address_acc_r, address_acc_nxt;

  logic [PENDING_DEPTH-1:0] pending_valid_r, pending_valid_nxt;
  logic [15:0]              pending_ident_r [PENDING_DEPTH];
  logic [7:0]               pending_tag_r   [PENDING_DEPTH];

  logic        out_valid_r, out_valid_nxt;
  logic        out_status_r, out_status_nxt;
  logic [31:0] out_address_r, out_address_nxt;
  logic [7:0]  out_tag_r, out_tag_nxt;

  logic                  in_fire;
  logic                  add_fire;
  logic                  byte_fire;
  logic                  table_full;
  logic [PEND_IDX_W-1:0] free_idx;
  logic                  match_any;
  logic [PEND_IDX_W-1:0] match_idx;
  logic [15:0]           count_inc;
  logic [15:0]           count_dec;
  logic [15:0]           length_word;
  logic [31:0]           address_word;

  assign in_item.ready = !out_valid_r || out_result.ready;
  assign in_fire       = in_item.valid && in_item.ready;
  assign add_fire      = in_fire && (in_item.action == ACT_ADD);
  assign byte_fire     = in_fire && (in_item.action == ACT_BYTE);

  assign out_result.valid            = out_valid_r;
  assign out_result.status           = out_status_r;
  assign out_result.resolved_address = out_address_r;
  assign out_result.tag_out          = out_tag_r;

  assign count_inc    = byte_count_r + 16'd1;
  assign count_dec    = byte_count_r - 16'd1;
  assign length_word  = {data_length_r[15:8], in_item.packet_byte};
  assign address_word = {address_acc_r[23:0], in_item.packet_byte};
  assign table_full   = &pending_valid_r;

  // Lowest free entry and lowest valid entry holding the packet identifier.
  always_comb begin
    free_idx  = '0;
    match_any = 1'b0;
    match_idx = '0;
    for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
      if (!pending_valid_r[i]) begin
        free_idx = PEND_IDX_W'(i);
      end
      if (pending_valid_r[i] && (pending_ident_r[i] == packet_ident_r)) begin
        match_any = 1'b1;
        match_idx = PEND_IDX_W'(i);
      end
    end
  end

  function automatic phase_t next_section(input logic [15:0] q_left,
                                          input logic [15:0] a_left);
    phase_t ph;
    if (q_left != 16'd0) begin
      ph = PH_QLEN;
    end else if (a_left != 16'd0) begin
      ph = PH_ALEN;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  always_comb begin
    phase_nxt          = phase_r;
    byte_count_nxt     = byte_count_r;
    questions_left_nxt = questions_left_r;
    answers_left_nxt   = answers_left_r;
    packet_ident_nxt   = packet_ident_r;
    record_kind_nxt    = record_kind_r;
    data_length_nxt    = data_length_r;
    address_acc_nxt    = address_acc_r;
    pending_valid_nxt  = pending_valid_r;
    out_status_nxt     = out_status_r;
    out_address_nxt    = out_address_r;
    out_tag_nxt        = out_tag_r;
    out_valid_nxt      = out_valid_r && !out_result.ready;

    if (add_fire) begin
      if (table_full) begin
        out_valid_nxt   = 1'b1;
        out_status_nxt  = STATUS_FULL;
        out_address_nxt = '0;
        out_tag_nxt     = in_item.request_tag;
      end else begin
        pending_valid_nxt[free_idx] = 1'b1;
      end
    end

    if (byte_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          // Identifier in bytes 0 and 1, question count in 4 and 5, answer count in 6 and 7.
          unique case (byte_count_r)
            16'd0:   packet_ident_nxt   = {in_item.packet_byte, 8'h00};
            16'd1:   packet_ident_nxt   = {packet_ident_r[15:8], in_item.packet_byte};
            16'd4:   questions_left_nxt = {in_item.packet_byte, 8'h00};
            16'd5:   questions_left_nxt = {questions_left_r[15:8], in_item.packet_byte};
            16'd6:   answers_left_nxt   = {in_item.packet_byte, 8'h00};
            16'd7:   answers_left_nxt   = {answers_left_r[15:8], in_item.packet_byte};
            default: ;
          endcase
          byte_count_nxt = count_inc;
          if (count_inc >= HDR_LEN) begin
            byte_count_nxt = '0;
            phase_nxt      = next_section(questions_left_r, answers_left_r);
          end
        end
        PH_QLEN, PH_ALEN: begin
          byte_count_nxt = '0;
          if ((in_item.packet_byte & POINTER_MASK) != 8'h00) begin
            phase_nxt = (phase_r == PH_QLEN) ? PH_QPTR : PH_APTR;
          end else if (in_item.packet_byte == 8'h00) begin
            phase_nxt = (phase_r == PH_QLEN) ? PH_QFOOT : PH_AFOOT;
          end else begin
            byte_count_nxt = {8'h00, in_item.packet_byte};
            phase_nxt      = (phase_r == PH_QLEN) ? PH_QSKIP : PH_ASKIP;
          end
        end
        PH_QSKIP, PH_ASKIP: begin
          byte_count_nxt = count_dec;
          if (count_dec == 16'd0) begin
            phase_nxt = (phase_r == PH_QSKIP) ? PH_QLEN : PH_ALEN;
          end
        end
        PH_QPTR: begin
          byte_count_nxt = '0;
          phase_nxt      = PH_QFOOT;
        end
        PH_APTR: begin
          byte_count_nxt = '0;
          phase_nxt      = PH_AFOOT;
        end
        PH_QFOOT: begin
          byte_count_nxt = count_inc;
          if (count_inc >= QFOOT_LEN) begin
            questions_left_nxt = questions_left_r - 16'd1;
            byte_count_nxt     = '0;
            phase_nxt          = next_section(questions_left_r - 16'd1, answers_left_r);
          end
        end
        PH_AFOOT: begin
          // Type in bytes 0 and 1, data length in bytes 8 and 9 of the footer.
          unique case (byte_count_r)
            16'd0:   record_kind_nxt = {in_item.packet_byte, 8'h00};
            16'd1:   record_kind_nxt = {record_kind_r[15:8], in_item.packet_byte};
            16'd8:   data_length_nxt = {in_item.packet_byte, 8'h00};
            16'd9:   data_length_nxt = length_word;
            default: ;
          endcase
          byte_count_nxt = count_inc;
          if (count_inc >= AFOOT_LEN) begin
            byte_count_nxt = '0;
            if (record_kind_r == TYPE_A) begin
              address_acc_nxt = '0;
              phase_nxt       = PH_ADDR;
            end else if (length_word == 16'd0) begin
              answers_left_nxt = answers_left_r - 16'd1;
              phase_nxt        = next_section(questions_left_r, answers_left_r - 16'd1);
            end else begin
              byte_count_nxt = length_word;
              phase_nxt      = PH_RSKIP;
            end
          end
        end
        PH_RSKIP: begin
          byte_count_nxt = count_dec;
          if (count_dec == 16'd0) begin
            answers_left_nxt = answers_left_r - 16'd1;
            phase_nxt        = next_section(questions_left_r, answers_left_r - 16'd1);
          end
        end
        PH_ADDR: begin
          address_acc_nxt = address_word;
          byte_count_nxt  = count_inc;
          if (count_inc >= ADDR_LEN) begin
            if (match_any) begin
              pending_valid_nxt[match_idx] = 1'b0;
              out_valid_nxt                = 1'b1;
              out_status_nxt               = STATUS_RESOLVED;
              out_address_nxt              = address_word;
              out_tag_nxt                  = pending_tag_r[match_idx];
            end
            answers_left_nxt = answers_left_r - 16'd1;
            byte_count_nxt   = '0;
            phase_nxt        = next_section(questions_left_r, answers_left_r - 16'd1);
          end
        end
        PH_DONE: ;
        default: ;
      endcase

      // The end mark on a byte item restarts the parse, whatever was still open.
      if (in_item.end_of_packet) begin
        phase_nxt      = PH_HEADER;
        byte_count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HEADER;
      byte_count_r     <= '0;
      questions_left_r <= '0;
      answers_left_r   <= '0;
      packet_ident_r   <= '0;
      record_kind_r    <= '0;
      data_length_r    <= '0;
      address_acc_r    <= '0;
      pending_valid_r  <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      byte_count_r     <= byte_count_nxt;
      questions_left_r <= questions_left_nxt;
      answers_left_r   <= answers_left_nxt;
      packet_ident_r   <= packet_ident_nxt;
      record_kind_r    <= record_kind_nxt;
      data_length_r    <= data_length_nxt;
      address_acc_r    <= address_acc_nxt;
      pending_valid_r  <= pending_valid_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_address_r <= out_address_nxt;
    out_tag_r     <= out_tag_nxt;
    if (add_fire && !table_full) begin
      pending_ident_r[free_idx] <= in_item.query_id;
      pending_tag_r[free_idx]   <= in_item.request_tag;
    end
  end

`ifndef NO_ASSERTIONS
  a_full_reports: assert property (@(posedge clk) disable iff (!rst_n)
    add_fire && table_full |=> out_valid_r && (out_status_r == STATUS_FULL))
    else $error("add to a full table gave no overflow result");

  a_add_claims_entry: assert property (@(posedge clk) disable iff (!rst_n)
    add_fire && !table_full |=>
      $countones(pending_valid_r) == $past($countones(pending_valid_r)) + 1)
    else $error("add did not claim exactly one entry");

  a_eop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    byte_fire && in_item.end_of_packet |=> (phase_r == PH_HEADER) && (byte_count_r == 16'd0))
    else $error("end of packet did not restart the parse");
`endif

endmodule
`default_nettype wire
